FILE: hw/rtl/wlvg_pkg.sv
// Shared types, codes and reset values for the water leak valve guard.
`timescale 1ns / 1ps

package wlvg_pkg;

  localparam int unsigned MaxResults = 3;

  // input opcodes
  localparam logic [3:0] OP_PULSE       = 4'd0;
  localparam logic [3:0] OP_TICK        = 4'd1;
  localparam logic [3:0] OP_OPEN        = 4'd2;
  localparam logic [3:0] OP_CLOSE       = 4'd3;
  localparam logic [3:0] OP_FLOW        = 4'd4;
  localparam logic [3:0] OP_CONSUMPTION = 4'd5;
  localparam logic [3:0] OP_LAPSE_START = 4'd6;
  localparam logic [3:0] OP_LAPSE_END   = 4'd7;
  localparam logic [3:0] OP_VALVE       = 4'd8;
  localparam logic [3:0] OP_DAILY_RPT   = 4'd9;
  localparam logic [3:0] OP_SET_LIMIT   = 4'd10;

  // result events
  localparam logic [3:0] EV_FLOW         = 4'd0;
  localparam logic [3:0] EV_CONSUMPTION  = 4'd1;
  localparam logic [3:0] EV_LAPSE_START  = 4'd2;
  localparam logic [3:0] EV_LAPSE_VALUE  = 4'd3;
  localparam logic [3:0] EV_VALVE_STATUS = 4'd4;
  localparam logic [3:0] EV_DAILY_RPT    = 4'd5;
  localparam logic [3:0] EV_LIMIT_ARMED  = 4'd6;
  localparam logic [3:0] EV_OPENED       = 4'd7;
  localparam logic [3:0] EV_CLOSED       = 4'd8;
  localparam logic [3:0] EV_DAILY_CLOSE  = 4'd9;
  localparam logic [3:0] EV_MANUAL_CLOSE = 4'd10;
  localparam logic [3:0] EV_CONT_CLOSE   = 4'd11;
  localparam logic [3:0] EV_PERIODIC_RPT = 4'd12;

  // configuration register indexes
  localparam logic [2:0] REG_DAILY_LIMIT = 3'd0;
  localparam logic [2:0] REG_PPL         = 3'd1;
  localparam logic [2:0] REG_CONT_LIMIT  = 3'd2;
  localparam logic [2:0] REG_DAY_WINDOW  = 3'd3;
  localparam logic [2:0] REG_REPORT      = 3'd4;

  localparam logic [31:0] DailyLimitReset = 32'd1980000;
  localparam logic [15:0] PplReset        = 16'd396;
  localparam logic [16:0] ContLimitReset  = 17'd18000;
  localparam logic [16:0] DayWindowReset  = 17'd86400;
  localparam logic [16:0] ReportReset     = 17'd3600;

  typedef struct packed {
    logic [31:0] daily_limit_pulses;
    logic [15:0] pulses_per_litre;
    logic [16:0] continuous_limit_seconds;
    logic [16:0] day_window_seconds;
    logic [16:0] report_period_seconds;
  } cfg_t;

  typedef struct packed {
    logic [15:0] window_pulses;
    logic [15:0] last_flow_pulses;
    logic [31:0] day_pulses;
    logic [31:0] period_pulses;
    logic [31:0] report_day_pulses;
    logic [31:0] lapse_mark;
    logic [31:0] manual_limit;
    logic        manual_active;
    logic        valve_is_open;
    logic [16:0] day_seconds;
    logic [16:0] flow_seconds;
    logic [16:0] period_seconds;
  } state_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [31:0] value;
    logic        valve_open;
    logic        last;
  } res_t;

  localparam cfg_t CfgReset = '{
    daily_limit_pulses:       DailyLimitReset,
    pulses_per_litre:         PplReset,
    continuous_limit_seconds: ContLimitReset,
    day_window_seconds:       DayWindowReset,
    report_period_seconds:    ReportReset
  };

  localparam state_t StateReset = '{
    window_pulses:     '0,
    last_flow_pulses:  '0,
    day_pulses:        '0,
    period_pulses:     '0,
    report_day_pulses: '0,
    lapse_mark:        '0,
    manual_limit:      '0,
    manual_active:     1'b0,
    valve_is_open:     1'b1,
    day_seconds:       '0,
    flow_seconds:      '0,
    period_seconds:    '0
  };

  function automatic res_t make_res(logic [3:0] ev, logic [31:0] val, logic open);
    res_t r;
    r.event_res  = ev;
    r.value      = val;
    r.valve_open = open;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] sat_inc32(logic [31:0] x);
    return (x == '1) ? x : x + 32'd1;
  endfunction

endpackage

FILE: hw/rtl/water_leak_valve_guard_core.sv
// Top level of the water leak valve guard: ports, registers and output staging.
//
// Input stream (s_axis_*): one item per transfer; tuser is the opcode
// (pulse, tick or remote command), tdata carries litres for set-limit.
// Output stream (m_axis_*): zero to three result transfers per input item,
// in order; tlast marks the final result of an item. tuser is the event
// code, tdata holds the pulse count and the valve state.
// Configuration: cfg_we writes cfg_data to register cfg_index at the clock
// edge; writes to indexes past the register list are dropped.
// An item's results pass through the input register, the result bundle
// register and the output register, in that order.
// Throughput: one item per cycle while each item gives at most one result
// and the receiver is ready; an item with more results holds the bundle
// register while the single output register drains them one per cycle.
// Reset (rst, synchronous): counters clear, valve reads open, registers
// take their default values, no output is valid.
// When the receiver stalls, the output and bundle registers hold and
// s_axis_tready drops once the input register is also full.
`timescale 1ns / 1ps

module water_leak_valve_guard_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] litres
  input  logic [3:0]  s_axis_tuser,   // [3:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] value, [32] valve_open, [39:33] zero
  output logic [3:0]  m_axis_tuser,   // [3:0] event_res
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  wlvg_pkg::cfg_t   cfg;
  wlvg_pkg::state_t st;
  wlvg_pkg::state_t st_next;

  logic        in_valid;
  logic [3:0]  in_opcode;
  logic [15:0] in_litres;

  wlvg_pkg::res_t step_res [wlvg_pkg::MaxResults];
  logic [1:0]     step_cnt;

  wlvg_pkg::res_t bnd_res [wlvg_pkg::MaxResults];
  logic [1:0]     bnd_cnt;
  logic [1:0]     bnd_idx;

  logic           out_valid;
  wlvg_pkg::res_t out_res;

  logic out_load;
  logic bnd_free;
  logic proc_fire;

  assign out_load  = (bnd_cnt != 2'd0) && (!out_valid || m_axis_tready);
  assign bnd_free  = (bnd_cnt == 2'd0) || ((bnd_cnt == 2'd1) && out_load);
  assign proc_fire = in_valid && bnd_free;
  assign s_axis_tready = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= wlvg_pkg::CfgReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wlvg_pkg::REG_DAILY_LIMIT: cfg.daily_limit_pulses       <= cfg_data;
        wlvg_pkg::REG_PPL:         cfg.pulses_per_litre         <= cfg_data[15:0];
        wlvg_pkg::REG_CONT_LIMIT:  cfg.continuous_limit_seconds <= cfg_data[16:0];
        wlvg_pkg::REG_DAY_WINDOW:  cfg.day_window_seconds       <= cfg_data[16:0];
        wlvg_pkg::REG_REPORT:      cfg.report_period_seconds    <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_opcode <= s_axis_tuser;
      in_litres <= s_axis_tdata;
    end
  end

  wlvg_step u_step (
    .opcode  (in_opcode),
    .litres  (in_litres),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .res     (step_res),
    .res_cnt (step_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= wlvg_pkg::StateReset;
    end else if (proc_fire) begin
      st <= st_next;
    end
  end

  // result bundle, drained one result per cycle while the output register loads
  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_cnt <= 2'd0;
      bnd_idx <= 2'd0;
    end else if (proc_fire) begin
      bnd_cnt <= step_cnt;
      bnd_idx <= 2'd0;
    end else if (out_load) begin
      bnd_cnt <= bnd_cnt - 2'd1;
      bnd_idx <= bnd_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      bnd_res <= step_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= bnd_res[bnd_idx];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_res.valve_open, out_res.value};
  assign m_axis_tuser  = out_res.event_res;
  assign m_axis_tlast  = out_res.last;

endmodule

FILE: hw/rtl/wlvg_step.sv
// Next-state and result logic for one item of the valve guard.
`timescale 1ns / 1ps

module wlvg_step (
  input  logic [3:0]      opcode,
  input  logic [15:0]     litres,
  input  wlvg_pkg::cfg_t   cfg,
  input  wlvg_pkg::state_t st,
  output wlvg_pkg::state_t st_next,
  output wlvg_pkg::res_t   res [wlvg_pkg::MaxResults],
  output logic [1:0]      res_cnt
);

  logic [17:0] day_t;
  logic [17:0] flow_t;
  logic [17:0] period_t;
  logic [31:0] limit_prod;
  wlvg_pkg::res_t list [wlvg_pkg::MaxResults];
  logic [1:0]  n;

  assign day_t      = {1'b0, st.day_seconds} + 18'd1;
  assign flow_t     = {1'b0, st.flow_seconds} + 18'd1;
  assign period_t   = {1'b0, st.period_seconds} + 18'd1;
  assign limit_prod = {16'b0, litres} * {16'b0, cfg.pulses_per_litre};

  always_comb begin
    st_next = st;
    n = 2'd0;
    for (int i = 0; i < wlvg_pkg::MaxResults; i++) begin
      list[i] = '0;
    end
    unique case (opcode)
      wlvg_pkg::OP_PULSE: begin
        if (st.window_pulses != 16'hFFFF) begin
          st_next.window_pulses = st.window_pulses + 16'd1;
        end
        st_next.day_pulses        = wlvg_pkg::sat_inc32(st.day_pulses);
        st_next.period_pulses     = wlvg_pkg::sat_inc32(st.period_pulses);
        st_next.report_day_pulses = wlvg_pkg::sat_inc32(st.report_day_pulses);
      end
      wlvg_pkg::OP_TICK: begin
        st_next.last_flow_pulses = st.window_pulses;
        st_next.window_pulses    = '0;
        // limit check
        if (!st.manual_active && (st.day_pulses > cfg.daily_limit_pulses)) begin
          st_next.valve_is_open = 1'b0;
          list[n] = wlvg_pkg::make_res(wlvg_pkg::EV_DAILY_CLOSE, st.day_pulses, 1'b0);
          n = n + 2'd1;
          st_next.day_pulses = '0;
        end else if (st.manual_active && (st.day_pulses > st.manual_limit)) begin
          st_next.valve_is_open = 1'b0;
          list[n] = wlvg_pkg::make_res(wlvg_pkg::EV_MANUAL_CLOSE, st.day_pulses, 1'b0);
          n = n + 2'd1;
          st_next.day_pulses    = '0;
          st_next.manual_active = 1'b0;
        end
        // day window
        if (day_t >= {1'b0, cfg.day_window_seconds}) begin
          st_next.day_pulses    = '0;
          st_next.day_seconds   = '0;
          st_next.manual_active = 1'b0;
        end else begin
          st_next.day_seconds = day_t[16:0];
        end
        // unbroken flow
        if (st.window_pulses == '0) begin
          st_next.flow_seconds = '0;
        end else if (flow_t >= {1'b0, cfg.continuous_limit_seconds}) begin
          st_next.flow_seconds  = '0;
          st_next.valve_is_open = 1'b0;
          list[n] = wlvg_pkg::make_res(wlvg_pkg::EV_CONT_CLOSE, '0, 1'b0);
          n = n + 2'd1;
        end else begin
          st_next.flow_seconds = flow_t[16:0];
        end
        // periodic report
        if (period_t >= {1'b0, cfg.report_period_seconds}) begin
          list[n] = wlvg_pkg::make_res(wlvg_pkg::EV_PERIODIC_RPT, st.period_pulses,
                                       st_next.valve_is_open);
          n = n + 2'd1;
          st_next.period_pulses  = '0;
          st_next.period_seconds = '0;
        end else begin
          st_next.period_seconds = period_t[16:0];
        end
      end
      wlvg_pkg::OP_OPEN: begin
        st_next.valve_is_open = 1'b1;
        list[0] = wlvg_pkg::make_res(wlvg_pkg::EV_OPENED, '0, 1'b1);
        n = 2'd1;
      end
      wlvg_pkg::OP_CLOSE: begin
        st_next.valve_is_open = 1'b0;
        list[0] = wlvg_pkg::make_res(wlvg_pkg::EV_CLOSED, '0, 1'b0);
        n = 2'd1;
      end
      wlvg_pkg::OP_FLOW: begin
        list[0] = wlvg_pkg::make_res(wlvg_pkg::EV_FLOW, {16'b0, st.last_flow_pulses},
                                     st.valve_is_open);
        n = 2'd1;
      end
      wlvg_pkg::OP_CONSUMPTION: begin
        list[0] = wlvg_pkg::make_res(wlvg_pkg::EV_CONSUMPTION, st.day_pulses,
                                     st.valve_is_open);
        n = 2'd1;
      end
      wlvg_pkg::OP_LAPSE_START: begin
        st_next.lapse_mark = st.day_pulses;
        list[0] = wlvg_pkg::make_res(wlvg_pkg::EV_LAPSE_START, '0, st.valve_is_open);
        n = 2'd1;
      end
      wlvg_pkg::OP_LAPSE_END: begin
        list[0] = wlvg_pkg::make_res(wlvg_pkg::EV_LAPSE_VALUE,
                                     st.day_pulses - st.lapse_mark, st.valve_is_open);
        n = 2'd1;
      end
      wlvg_pkg::OP_VALVE: begin
        list[0] = wlvg_pkg::make_res(wlvg_pkg::EV_VALVE_STATUS, '0, st.valve_is_open);
        n = 2'd1;
      end
      wlvg_pkg::OP_DAILY_RPT: begin
        list[0] = wlvg_pkg::make_res(wlvg_pkg::EV_DAILY_RPT, st.report_day_pulses,
                                     st.valve_is_open);
        n = 2'd1;
        st_next.report_day_pulses = '0;
        st_next.period_seconds    = '0;
      end
      wlvg_pkg::OP_SET_LIMIT: begin
        st_next.manual_limit  = limit_prod;
        st_next.manual_active = 1'b1;
        st_next.day_pulses    = '0;
        st_next.day_seconds   = '0;
        list[0] = wlvg_pkg::make_res(wlvg_pkg::EV_LIMIT_ARMED, limit_prod,
                                     st.valve_is_open);
        n = 2'd1;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < wlvg_pkg::MaxResults; i++) begin
      res[i]      = list[i];
      res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
    res_cnt = n;
  end

endmodule

FILE: hw/rtl/wlvg_checker.sv
// Port-level assertions for the valve guard, bound to the top level.
`timescale 1ns / 1ps

module wlvg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic close_ev;
  logic zero_ev;

  assign close_ev = (m_axis_tuser == wlvg_pkg::EV_CLOSED) ||
                    (m_axis_tuser == wlvg_pkg::EV_DAILY_CLOSE) ||
                    (m_axis_tuser == wlvg_pkg::EV_MANUAL_CLOSE) ||
                    (m_axis_tuser == wlvg_pkg::EV_CONT_CLOSE);
  assign zero_ev  = (m_axis_tuser == wlvg_pkg::EV_LAPSE_START) ||
                    (m_axis_tuser == wlvg_pkg::EV_VALVE_STATUS) ||
                    (m_axis_tuser == wlvg_pkg::EV_OPENED) ||
                    (m_axis_tuser == wlvg_pkg::EV_CLOSED) ||
                    (m_axis_tuser == wlvg_pkg::EV_CONT_CLOSE);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output valid or input blocked after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output transfer changed");

  a_open_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == wlvg_pkg::EV_OPENED) |-> m_axis_tdata[32])
    else $error("opened event with valve shown closed");

  a_close_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && close_ev |-> !m_axis_tdata[32])
    else $error("close event with valve shown open");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && zero_ev |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("event without a count carries a nonzero value");

endmodule

bind water_leak_valve_guard_core wlvg_checker u_wlvg_checker (.*);
